/* rtl/core/lipc_pkg.sv */
// lipc_pkg: shared types and constants for the led indicator pattern controller
package lipc_pkg;

    // request kinds
    typedef enum logic [2:0] {
        REQ_COND    = 3'd0,
        REQ_READY   = 3'd1,
        REQ_PROFILE = 3'd2,
        REQ_POLL    = 3'd3,
        REQ_SENT    = 3'd4
    } req_kind_t;

    // overlay modes
    typedef enum logic [1:0] {
        OV_NONE    = 2'd0,
        OV_READY   = 2'd1,
        OV_PROFILE = 2'd2
    } overlay_t;

    localparam int SEG_W = 5;
    localparam int TIME_W = 32;

    localparam logic [SEG_W-1:0] ALL_SEGS   = 5'h1f;
    localparam logic [SEG_W-1:0] OUTER_SEGS = 5'h11;
    localparam logic [SEG_W-1:0] NO_SEGS    = 5'h00;
    localparam logic [SEG_W-1:0] SEGS_1     = 5'h01;
    localparam logic [SEG_W-1:0] SEGS_2     = 5'h03;
    localparam logic [SEG_W-1:0] SEGS_3     = 5'h07;
    localparam logic [SEG_W-1:0] SEGS_4     = 5'h0f;

    localparam logic [TIME_W-1:0] REFRESH_MS      = 32'd100;
    localparam logic [TIME_W-1:0] SWEEP_STEP_MS   = 32'd140;
    localparam logic [TIME_W-1:0] SWEEP_END_MS    = 32'd840;
    localparam logic [TIME_W-1:0] PROFILE_SPAN_MS = 32'd2400;
    localparam logic [TIME_W-1:0] DARK1_START_MS  = 32'd500;
    localparam logic [TIME_W-1:0] DARK1_END_MS    = 32'd700;
    localparam logic [TIME_W-1:0] DARK2_START_MS  = 32'd1200;
    localparam logic [TIME_W-1:0] DARK2_END_MS    = 32'd1400;

    // x/150 = (x>>1)/75 = ((x>>1) * FAULT_RECIP) >> FAULT_SHIFT, exact for 31-bit x>>1
    localparam logic [31:0] FAULT_RECIP = 32'd3665038760;
    localparam int          FAULT_SHIFT = 38;
    // x/500 = (x>>2)/125 = ((x>>2) * AUTH_RECIP) >> AUTH_SHIFT, exact for 30-bit x>>2
    localparam logic [30:0] AUTH_RECIP  = 31'd1099511628;
    localparam int          AUTH_SHIFT  = 37;

    // sweep mask for a time into the ready overlay known to be below 840 ms
    function automatic logic [SEG_W-1:0] sweep_mask(input logic [TIME_W-1:0] el);
        logic [SEG_W-1:0] m;
        begin
            if (el < SWEEP_STEP_MS)
                m = SEGS_1;
            else if (el < 2 * SWEEP_STEP_MS)
                m = SEGS_2;
            else if (el < 3 * SWEEP_STEP_MS)
                m = SEGS_3;
            else if (el < 4 * SWEEP_STEP_MS)
                m = SEGS_4;
            else if (el < 5 * SWEEP_STEP_MS)
                m = ALL_SEGS;
            else
                m = NO_SEGS;
            return m;
        end
    endfunction

    // bar of 1..5 lit segments from a profile number
    function automatic logic [SEG_W-1:0] bar_from_profile(input logic [7:0] prof);
        logic [SEG_W-1:0] m;
        begin
            if (prof <= 8'd1)
                m = SEGS_1;
            else if (prof == 8'd2)
                m = SEGS_2;
            else if (prof == 8'd3)
                m = SEGS_3;
            else if (prof == 8'd4)
                m = SEGS_4;
            else
                m = ALL_SEGS;
            return m;
        end
    endfunction

endpackage

/* rtl/core/led_indicator_pattern_controller_top.sv */
// led_indicator_pattern_controller_top: three-register pipeline for led bar events
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid, req_ready  | req_type, now_ms, auth_flag, fault_flag,
//          |           |                       | profile_num, sent_mask
//  rsp     | out       | rsp_valid, rsp_ready  | send_due, led_mask
//
// one item per cycle while results are taken; an accepted item passes through the input
// register, the blink-phase multiply register and the result register
// all condition and overlay state is updated as an item leaves the middle register;
// the blink phase time base is forwarded from that register into the multiplies
// reset clears all state and empties the pipeline
// a stalled result backs up the pipeline one register at a time; empty registers
// keep accepting items
module led_indicator_pattern_controller_top
    import lipc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic        auth_flag,
    input  logic        fault_flag,
    input  logic [7:0]  profile_num,
    input  logic [4:0]  sent_mask,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        send_due,
    output logic [4:0]  led_mask
);

    // item held in a pipeline register
    typedef struct packed {
        logic [2:0]        req;
        logic [TIME_W-1:0] now;
        logic              auth;
        logic              fault;
        logic [7:0]        prof;
        logic [SEG_W-1:0]  smask;
    } item_t;

    // pipeline registers
    logic              s1_valid_reg, s1_valid_next;
    item_t             s1_item_reg;
    logic              s2_valid_reg, s2_valid_next;
    item_t             s2_item_reg;
    logic              s2_fault_odd_reg;
    logic              s2_auth_odd_reg;
    logic              out_valid_reg, out_valid_next;
    logic              send_due_reg, send_due_next;
    logic [SEG_W-1:0]  led_mask_reg, led_mask_next;

    // block state
    logic              auth_seen_reg, auth_seen_next;
    logic              fault_seen_reg, fault_seen_next;
    logic [TIME_W-1:0] cond_change_time_reg, cond_change_time_next;
    overlay_t          overlay_mode_reg, overlay_mode_next;
    logic [TIME_W-1:0] overlay_start_time_reg, overlay_start_time_next;
    logic [SEG_W-1:0]  profile_bar_reg, profile_bar_next;
    logic [SEG_W-1:0]  last_sent_mask_reg, last_sent_mask_next;
    logic              last_sent_valid_reg, last_sent_valid_next;
    logic [TIME_W-1:0] last_sent_time_reg, last_sent_time_next;
    logic              override_on_reg, override_on_next;

    // flow control
    logic out_load;
    logic s2_load;
    logic s1_load;

    assign out_load  = !out_valid_reg || rsp_ready;
    assign s2_load   = !s2_valid_reg || out_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign req_ready = s1_load;

    assign s1_valid_next  = s1_load ? req_valid : s1_valid_reg;
    assign s2_valid_next  = s2_load ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_load ? s2_valid_reg : out_valid_reg;

    // condition change of the item in the middle register
    logic cond_chg;
    assign cond_chg = (s2_item_reg.auth != auth_seen_reg)
                   || (s2_item_reg.fault != fault_seen_reg);

    // blink phase: forward a pending condition change, then divide by reciprocal
    logic [TIME_W-1:0] cc_eff;
    logic [TIME_W-1:0] since_cond;
    logic [62:0]       fault_prod;
    logic [61:0]       auth_prod;

    always_comb
    begin
        if (s2_valid_reg && (s2_item_reg.req == REQ_COND) && cond_chg)
            cc_eff = s2_item_reg.now;
        else
            cc_eff = cond_change_time_reg;
        since_cond = s1_item_reg.now - cc_eff;
        fault_prod = 63'(since_cond[TIME_W-1:1]) * 63'(FAULT_RECIP);
        auth_prod  = 62'(since_cond[TIME_W-1:2]) * 62'(AUTH_RECIP);
    end

    // pattern evaluation for the item in the middle register
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] since_sent;
    logic              pat_on;
    logic [SEG_W-1:0]  pat_mask;
    logic              ov_drop;

    always_comb
    begin
        el         = s2_item_reg.now - overlay_start_time_reg;
        since_sent = s2_item_reg.now - last_sent_time_reg;
        pat_on     = 1'b0;
        pat_mask   = NO_SEGS;
        ov_drop    = 1'b0;
        if (fault_seen_reg)
        begin
            pat_on   = 1'b1;
            pat_mask = s2_fault_odd_reg ? NO_SEGS : ALL_SEGS;
        end
        else
        begin
            if (overlay_mode_reg == OV_READY)
            begin
                if (el < SWEEP_END_MS)
                begin
                    pat_on   = 1'b1;
                    pat_mask = sweep_mask(el);
                end
                else
                begin
                    ov_drop = 1'b1;
                end
            end
            else if (overlay_mode_reg == OV_PROFILE)
            begin
                if (el < PROFILE_SPAN_MS)
                begin
                    pat_on = 1'b1;
                    if ((el >= DARK1_START_MS && el < DARK1_END_MS)
                        || (el >= DARK2_START_MS && el < DARK2_END_MS))
                        pat_mask = NO_SEGS;
                    else
                        pat_mask = profile_bar_reg;
                end
                else
                begin
                    ov_drop = 1'b1;
                end
            end
            if (!pat_on && !auth_seen_reg)
            begin
                pat_on   = 1'b1;
                pat_mask = s2_auth_odd_reg ? NO_SEGS : OUTER_SEGS;
            end
        end
    end

    // state update and result as an item leaves the middle register
    logic s2_fire;
    assign s2_fire = s2_valid_reg && out_load;

    always_comb
    begin
        auth_seen_next          = auth_seen_reg;
        fault_seen_next         = fault_seen_reg;
        cond_change_time_next   = cond_change_time_reg;
        overlay_mode_next       = overlay_mode_reg;
        overlay_start_time_next = overlay_start_time_reg;
        profile_bar_next        = profile_bar_reg;
        last_sent_mask_next     = last_sent_mask_reg;
        last_sent_valid_next    = last_sent_valid_reg;
        last_sent_time_next     = last_sent_time_reg;
        override_on_next        = override_on_reg;
        send_due_next           = send_due_reg;
        led_mask_next           = led_mask_reg;
        if (s2_fire)
        begin
            send_due_next = 1'b0;
            led_mask_next = NO_SEGS;
            unique case (s2_item_reg.req)
                REQ_COND:
                begin
                    if (cond_chg)
                        cond_change_time_next = s2_item_reg.now;
                    auth_seen_next  = s2_item_reg.auth;
                    fault_seen_next = s2_item_reg.fault;
                end
                REQ_READY:
                begin
                    overlay_mode_next       = OV_READY;
                    overlay_start_time_next = s2_item_reg.now;
                    last_sent_valid_next    = 1'b0;
                end
                REQ_PROFILE:
                begin
                    profile_bar_next        = bar_from_profile(s2_item_reg.prof);
                    overlay_mode_next       = OV_PROFILE;
                    overlay_start_time_next = s2_item_reg.now;
                    last_sent_valid_next    = 1'b0;
                end
                REQ_POLL:
                begin
                    if (ov_drop)
                        overlay_mode_next = OV_NONE;
                    if (pat_on)
                    begin
                        override_on_next = 1'b1;
                        led_mask_next    = pat_mask;
                        send_due_next    = !last_sent_valid_reg
                                        || (pat_mask != last_sent_mask_reg)
                                        || (since_sent >= REFRESH_MS);
                    end
                    else if (override_on_reg)
                    begin
                        send_due_next = 1'b1;
                    end
                end
                REQ_SENT:
                begin
                    if (ov_drop)
                        overlay_mode_next = OV_NONE;
                    if (!pat_on && s2_item_reg.smask == NO_SEGS)
                    begin
                        override_on_next     = 1'b0;
                        last_sent_valid_next = 1'b0;
                    end
                    else
                    begin
                        last_sent_mask_next  = s2_item_reg.smask;
                        last_sent_valid_next = 1'b1;
                        last_sent_time_next  = s2_item_reg.now;
                    end
                end
                default:
                begin
                    // unused request codes leave state alone
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg           <= 1'b0;
            s2_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            auth_seen_reg          <= 1'b0;
            fault_seen_reg         <= 1'b0;
            cond_change_time_reg   <= '0;
            overlay_mode_reg       <= OV_NONE;
            overlay_start_time_reg <= '0;
            profile_bar_reg        <= NO_SEGS;
            last_sent_mask_reg     <= NO_SEGS;
            last_sent_valid_reg    <= 1'b0;
            last_sent_time_reg     <= '0;
            override_on_reg        <= 1'b0;
        end
        else
        begin
            s1_valid_reg           <= s1_valid_next;
            s2_valid_reg           <= s2_valid_next;
            out_valid_reg          <= out_valid_next;
            auth_seen_reg          <= auth_seen_next;
            fault_seen_reg         <= fault_seen_next;
            cond_change_time_reg   <= cond_change_time_next;
            overlay_mode_reg       <= overlay_mode_next;
            overlay_start_time_reg <= overlay_start_time_next;
            profile_bar_reg        <= profile_bar_next;
            last_sent_mask_reg     <= last_sent_mask_next;
            last_sent_valid_reg    <= last_sent_valid_next;
            last_sent_time_reg     <= last_sent_time_next;
            override_on_reg        <= override_on_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg.req   <= req_type;
            s1_item_reg.now   <= now_ms;
            s1_item_reg.auth  <= auth_flag;
            s1_item_reg.fault <= fault_flag;
            s1_item_reg.prof  <= profile_num;
            s1_item_reg.smask <= sent_mask;
        end
        if (s2_load)
        begin
            s2_item_reg      <= s1_item_reg;
            s2_fault_odd_reg <= fault_prod[FAULT_SHIFT];
            s2_auth_odd_reg  <= auth_prod[AUTH_SHIFT];
        end
        send_due_reg <= send_due_next;
        led_mask_reg <= led_mask_next;
    end

    assign rsp_valid = out_valid_reg;
    assign send_due  = send_due_reg;
    assign led_mask  = led_mask_reg;

endmodule

/* rtl/core/lipc_checker.sv */
// lipc_checker: port-level assertions for the led indicator pattern controller
module lipc_checker
    import lipc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        send_due,
    input logic [4:0]  led_mask
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result valid right after reset");

    // an empty result register never blocks a new item
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with no result pending");

    // every mask is one of the defined bar patterns
    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (led_mask == NO_SEGS || led_mask == SEGS_1 || led_mask == SEGS_2
                    || led_mask == SEGS_3 || led_mask == SEGS_4 || led_mask == ALL_SEGS
                    || led_mask == OUTER_SEGS))
        else $error("led mask outside the known patterns");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(send_due) && $stable(led_mask))
        else $error("stalled result changed");

endmodule

bind led_indicator_pattern_controller_top lipc_checker u_lipc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .send_due  (send_due),
    .led_mask  (led_mask)
);

/* test/tb.sv */
// tb: self-checking testbench for the led indicator pattern controller top level
module tb;
    import lipc_pkg::*;

    localparam int          RAND_ITEMS  = 1200;
    localparam int          CALM_FIRST  = 400;
    localparam int          CALM_LAST   = 600;
    localparam int          IDLE_PCT    = 27;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 12;
    localparam logic [2:0]  REQ_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  REQ_LAST_CODE    = 3'd7;
    localparam logic [31:0] FAULT_HALF_MS = 32'd150;
    localparam logic [31:0] AUTH_HALF_MS  = 32'd500;
    localparam logic [31:0] SWEEP_STEPS   = 32'd6;
    localparam logic [4:0]  SWEEP_TAB [6] = '{SEGS_1, SEGS_2, SEGS_3, SEGS_4, ALL_SEGS, NO_SEGS};

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now;
        logic        auth;
        logic        fault;
        logic [7:0]  prof;
        logic [4:0]  smask;
    } led_req_t;

    typedef struct packed {
        logic       due;
        logic [4:0] mask;
    } led_rsp_t;

    // a result written into the table, or left to the predictor
    typedef struct packed {
        logic     fixed;
        led_rsp_t rsp;
    } table_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  req_type = 3'd0;
    logic [31:0] now_ms = 32'd0;
    logic        auth_flag = 1'b0;
    logic        fault_flag = 1'b0;
    logic [7:0]  profile_num = 8'd0;
    logic [4:0]  sent_mask = 5'd0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic        send_due;
    logic [4:0]  led_mask;

    // predicted controller state
    logic        st_auth = 1'b0;
    logic        st_fault = 1'b0;
    logic [31:0] st_cond_t = 32'd0;
    overlay_t    st_ov = OV_NONE;
    logic [31:0] st_ov_t = 32'd0;
    logic [4:0]  st_bar = 5'd0;
    logic [4:0]  st_last_mask = 5'd0;
    logic        st_last_ok = 1'b0;
    logic [31:0] st_last_t = 32'd0;
    logic        st_override = 1'b0;
    logic [4:0]  last_poll_mask = 5'd0;

    led_req_t    dir_req_q [$];
    table_rsp_t  dir_rsp_q [$];
    table_rsp_t  table_rsp_q [$];
    led_rsp_t    led_expect_q [$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    logic        no_idle = 1'b0;

    led_indicator_pattern_controller_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .now_ms      (now_ms),
        .auth_flag   (auth_flag),
        .fault_flag  (fault_flag),
        .profile_num (profile_num),
        .sent_mask   (sent_mask),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .send_due    (send_due),
        .led_mask    (led_mask)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // wanted pattern at a time; an expired overlay is dropped on the way
    function automatic logic pattern_mask(input logic [31:0] now, output logic [4:0] mask);
        logic [31:0] since_cond;
        logic [31:0] el;
        logic [31:0] step;
        logic        live;
        logic        on;
        since_cond = now - st_cond_t;
        el = now - st_ov_t;
        live = 1'b0;
        on = 1'b1;
        mask = NO_SEGS;
        if (st_fault)
        begin
            mask = ((since_cond / FAULT_HALF_MS) & 32'd1) != 0 ? NO_SEGS : ALL_SEGS;
        end
        else
        begin
            if (st_ov == OV_READY)
            begin
                step = el / SWEEP_STEP_MS;
                if (step < SWEEP_STEPS)
                begin
                    mask = SWEEP_TAB[step[2:0]];
                    live = 1'b1;
                end
                else
                    st_ov = OV_NONE;
            end
            else if (st_ov == OV_PROFILE)
            begin
                if (el < PROFILE_SPAN_MS)
                begin
                    if ((el >= DARK1_START_MS && el < DARK1_END_MS) ||
                        (el >= DARK2_START_MS && el < DARK2_END_MS))
                        mask = NO_SEGS;
                    else
                        mask = st_bar;
                    live = 1'b1;
                end
                else
                    st_ov = OV_NONE;
            end
            if (!live)
            begin
                if (!st_auth)
                    mask = ((since_cond / AUTH_HALF_MS) & 32'd1) != 0 ? NO_SEGS : OUTER_SEGS;
                else
                    on = 1'b0;
            end
        end
        return on;
    endfunction

    // state update and result for one accepted item
    function automatic led_rsp_t predict_led(input led_req_t r);
        led_rsp_t   res;
        logic [4:0] m;
        int         pn;
        res = '0;
        m = NO_SEGS;
        case (r.kind)
            REQ_COND:
            begin
                if (r.auth != st_auth || r.fault != st_fault)
                    st_cond_t = r.now;
                st_auth = r.auth;
                st_fault = r.fault;
            end
            REQ_READY:
            begin
                st_ov = OV_READY;
                st_ov_t = r.now;
                st_last_ok = 1'b0;
            end
            REQ_PROFILE:
            begin
                pn = int'(r.prof);
                if (pn < 1)
                    pn = 1;
                if (pn > 5)
                    pn = 5;
                st_bar = 5'((1 << pn) - 1);
                st_ov = OV_PROFILE;
                st_ov_t = r.now;
                st_last_ok = 1'b0;
            end
            REQ_POLL:
            begin
                if (pattern_mask(r.now, m))
                begin
                    st_override = 1'b1;
                    res.mask = m;
                    res.due = !st_last_ok || m != st_last_mask ||
                              (r.now - st_last_t) >= REFRESH_MS;
                end
                else if (st_override)
                begin
                    res.mask = NO_SEGS;
                    res.due = 1'b1;
                end
                last_poll_mask = res.mask;
            end
            REQ_SENT:
            begin
                if (!pattern_mask(r.now, m) && r.smask == NO_SEGS)
                begin
                    st_override = 1'b0;
                    st_last_ok = 1'b0;
                end
                else
                begin
                    st_last_mask = r.smask;
                    st_last_ok = 1'b1;
                    st_last_t = r.now;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input logic [2:0] kind, input logic [31:0] now, input logic auth,
                           input logic fault, input logic [7:0] prof, input logic [4:0] smask,
                           input logic fixed, input logic due, input logic [4:0] mask);
        dir_req_q.push_back('{kind, now, auth, fault, prof, smask});
        dir_rsp_q.push_back('{fixed, '{due, mask}});
    endtask

    // one item on the request channel, with random idle cycles ahead of it
    task automatic drive_req(input led_req_t r);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= r.kind;
        now_ms      <= r.now;
        auth_flag   <= r.auth;
        fault_flag  <= r.fault;
        profile_num <= r.prof;
        sent_mask   <= r.smask;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // random item: time mostly creeps forward, with jumps and wraps now and then
    task automatic gen_item(inout logic [31:0] clock_ms, output led_req_t r);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms = clock_ms + $urandom_range(0, 80);
        else if (pick < 90)
            clock_ms = clock_ms + $urandom_range(80, 700);
        else if (pick < 96)
            clock_ms = clock_ms + $urandom_range(700, 3000);
        else if (pick < 98)
            clock_ms = $urandom();
        else
            clock_ms = 32'hffff_ffff - $urandom_range(0, 500);
        r.now   = clock_ms;
        r.auth  = 1'($urandom_range(0, 1));
        r.fault = 1'($urandom_range(0, 1));
        r.prof  = 8'($urandom_range(0, 255));
        r.smask = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.kind = REQ_POLL;
        else if (pick < 65)
        begin
            r.kind = REQ_SENT;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                r.smask = last_poll_mask;
            else if (pick < 8)
                r.smask = NO_SEGS;
        end
        else if (pick < 77)
        begin
            r.kind  = REQ_COND;
            r.fault = $urandom_range(0, 99) < 20;
            r.auth  = $urandom_range(0, 99) < 75;
        end
        else if (pick < 85)
            r.kind = REQ_READY;
        else if (pick < 93)
        begin
            r.kind = REQ_PROFILE;
            if ($urandom_range(0, 1) == 0)
                r.prof = 8'($urandom_range(0, 6));
        end
        else
            r.kind = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin
        led_rsp_t   want;
        led_rsp_t   pred;
        table_rsp_t row;
        led_req_t   r;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (led_expect_q.size() == 0)
                    report_mismatch("result with no item waiting",
                                    32'({send_due, led_mask}), 32'd0);
                else
                begin
                    want = led_expect_q.pop_front();
                    if (send_due !== want.due)
                        report_mismatch("send_due", 32'(send_due), 32'(want.due));
                    if (led_mask !== want.mask)
                        report_mismatch("led_mask", 32'(led_mask), 32'(want.mask));
                end
            end
            if (req_valid && req_ready)
            begin
                r = '{req_type, now_ms, auth_flag, fault_flag, profile_num, sent_mask};
                pred = predict_led(r);
                row = table_rsp_q.pop_front();
                led_expect_q.push_back(row.fixed ? row.rsp : pred);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        led_req_t    r;
        logic [31:0] clock_ms;
        int          real_cnt;
        clock_ms = 32'd0;
        real_cnt = 0;

        // directed table: after reset, flag changes, overlays, wraps, spare codes
        add_row(REQ_POLL,    32'd0,        1'b0, 1'b0, 8'd0,  5'h00, 1'b1, 1'b1, OUTER_SEGS);
        add_row(REQ_SENT,    32'd5,        1'b0, 1'b0, 8'd0,  5'h11, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd50,       1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_COND,    32'd1000,     1'b1, 1'b0, 8'd0,  5'h00, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd1010,     1'b1, 1'b0, 8'd0,  5'h00, 1'b1, 1'b1, NO_SEGS);
        add_row(REQ_SENT,    32'd1020,     1'b0, 1'b0, 8'd0,  5'h00, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd1030,     1'b0, 1'b0, 8'd0,  5'h00, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_COND,    32'd2000,     1'b1, 1'b1, 8'd0,  5'h00, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd2000,     1'b0, 1'b0, 8'd0,  5'h00, 1'b1, 1'b1, ALL_SEGS);
        add_row(REQ_SENT,    32'd2010,     1'b0, 1'b0, 8'd0,  5'h1f, 1'b1, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd2160,     1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_COND,    32'd3000,     1'b1, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_READY,   32'hffffff00, 1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'h00000010, 1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'h00000300, 1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_PROFILE, 32'd5000,     1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd5600,     1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_PROFILE, 32'd6000,     1'b0, 1'b0, 8'hff, 5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd6000,     1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_PROFILE, 32'd7000,     1'b0, 1'b0, 8'd3,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'd9400,     1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_SENT,    32'd9401,     1'b0, 1'b0, 8'd0,  5'h0a, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_COND,    32'hffffffff, 1'b0, 1'b1, 8'd0,  5'h15, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_POLL,    32'h7fffffff, 1'b0, 1'b0, 8'd0,  5'h00, 1'b0, 1'b0, NO_SEGS);
        add_row(REQ_FIRST_UNUSED,        32'hffffffff, 1'b1, 1'b1, 8'hff, 5'h1f,
                1'b1, 1'b0, NO_SEGS);
        add_row(REQ_FIRST_UNUSED + 3'd1, 32'hffffffff, 1'b1, 1'b1, 8'hff, 5'h1f,
                1'b1, 1'b0, NO_SEGS);
        add_row(REQ_LAST_CODE,           32'h5a5a5a5a, 1'b0, 1'b1, 8'h55, 5'h15,
                1'b1, 1'b0, NO_SEGS);

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_req_q.size(); i++)
        begin
            table_rsp_q.push_back(dir_rsp_q[i]);
            drive_req(dir_req_q[i]);
        end

        // random part, with a calm stretch in the middle
        while (real_cnt < RAND_ITEMS)
        begin
            no_idle = (real_cnt >= CALM_FIRST && real_cnt < CALM_LAST);
            gen_item(clock_ms, r);
            if (r.kind <= REQ_SENT)
                real_cnt++;
            table_rsp_q.push_back('0);
            drive_req(r);
        end
        req_valid <= 1'b0;
        no_idle = 1'b0;

        // let the last accepted item reach the scoreboard
        @(posedge clk);

        // drain
        while (led_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/lipc_pkg.sv
rtl/core/led_indicator_pattern_controller_top.sv
rtl/core/lipc_checker.sv
test/tb.sv
